// ===== design/buzzer_note_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// buzzer note sequencer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BUZZER_NOTE_SEQUENCER_DEFINES_SVH
`define BUZZER_NOTE_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, quiet during reset
`define BNS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, quiet during reset
`define BNS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bns_pkg.sv =====
// ----------------------------------------------------------------------------
// bns_pkg
// types and constants shared by the buzzer note sequencer modules
// ----------------------------------------------------------------------------
`default_nettype none

package bns_pkg;

   // note store depth and derived widths
   localparam int MAX_NOTES = 8;
   localparam int ADDR_W    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
   localparam int CNT_W     = $clog2(MAX_NOTES + 1);

   // command codes
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_CLEAR   = 2'd1;
   localparam logic [1:0] CMD_ENQUEUE = 2'd2;
   localparam logic [1:0] CMD_START   = 2'd3;

   // duty after reset
   localparam logic [7:0] DUTY_RESET = 8'd64;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] note_hz;
      logic [15:0] note_ms;
      logic [15:0] gap_ms;
   } req_word_type;

   typedef struct packed {
      logic        tone_on;
      logic [15:0] tone_hz;
      logic [7:0]  pwm_duty;
      logic        busy_res;
      logic        dropped;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] hz;
      logic [15:0] ms;
      logic [15:0] gap;
   } note_type;

   // player to note store control
   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } store_ctl_type;

endpackage

`default_nettype wire

// ===== design/buzzer_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// buzzer_note_sequencer
// plays a bounded queue of notes as tone, duty and busy words, one per command
// ----------------------------------------------------------------------------
// Each command word gives exactly one result word. Clear, enqueue, and ticks
// and starts that fetch no note have their result registered from the cycle
// in which the word is taken. A start, or a tick that moves on to the next
// note, fetches that note when it is in the store: the note is read from the
// note store, whose read data is registered, and the input stalls during that
// fetch. A start or tick that runs past the last note clears the queue without
// a fetch. The input also stalls while an unread result is held.
// The tone duty register may be written at any time the block is idle and
// applies to the next result.
`default_nettype none

module buzzer_note_sequencer
   import bns_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data
);

   logic [7:0]       tone_duty_ff;
   logic [7:0]       tone_duty_in;
   store_ctl_type    store_ctl;
   note_type         wr_note;
   note_type         rd_note;
   logic [CNT_W-1:0] note_count;
   logic             full;

   // tone duty register
   assign tone_duty_in = csr_wr_en ? csr_wr_data : tone_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_duty_ff <= DUTY_RESET;
      end else begin
         tone_duty_ff <= tone_duty_in;
      end
   end

   // note fields of an enqueue word
   assign wr_note.hz  = req_word.note_hz;
   assign wr_note.ms  = req_word.note_ms;
   assign wr_note.gap = req_word.gap_ms;

   bns_note_store u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (store_ctl),
      .wr_note    (wr_note),
      .rd_note    (rd_note),
      .note_count (note_count),
      .full       (full)
   );

   bns_player u_player (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .tone_duty  (tone_duty_ff),
      .store_ctl  (store_ctl),
      .rd_note    (rd_note),
      .note_count (note_count),
      .full       (full)
   );

endmodule

`default_nettype wire

// ===== design/bns_note_store.sv =====
// ----------------------------------------------------------------------------
// bns_note_store
// note memory with registered read and the fill count that appends go to
// ----------------------------------------------------------------------------
`default_nettype none

module bns_note_store
   import bns_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire store_ctl_type ctl,
   input  wire note_type      wr_note,
   output note_type           rd_note,
   output logic [CNT_W-1:0]   note_count,
   output logic               full
);

   note_type         note_mem [MAX_NOTES];
   note_type         rd_data_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // append at the fill count, read one entry per request
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         note_mem[count_ff[ADDR_W-1:0]] <= wr_note;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= note_mem[ctl.rd_addr];
      end
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_note    = rd_data_ff;
   assign note_count = count_ff;
   assign full       = (count_ff == CNT_W'(MAX_NOTES));

endmodule

`default_nettype wire

// ===== design/bns_player.sv =====
// ----------------------------------------------------------------------------
// bns_player
// command decode, phase timing, note load sequencing and result register
// ----------------------------------------------------------------------------
`default_nettype none

module bns_player
   import bns_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_word_type     req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_word_type          rsp_word,
   input  wire logic [7:0]       tone_duty,
   output store_ctl_type         store_ctl,
   input  wire note_type         rd_note,
   input  wire logic [CNT_W-1:0] note_count,
   input  wire logic             full
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] play_idx_ff, play_idx_in;
   logic             sounding_ff, sounding_in;
   logic             in_gap_ff, in_gap_in;
   logic [15:0]      remain_ff, remain_in;
   logic [15:0]      cur_hz_ff, cur_hz_in;
   logic [15:0]      cur_gap_ff, cur_gap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             req_accept;
   logic             begin_req;
   logic [CNT_W-1:0] begin_idx;
   logic             clear_all;
   logic             wr_en;
   logic             rd_en;
   logic             dropped;
   logic             rsp_load;
   logic [15:0]      remain_dec;
   logic [CNT_W-1:0] cnt_next;

   // a word is taken unless a note load is pending or the result is held
   assign req_stall  = (state_ff == ST_LOAD) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign remain_dec = (remain_ff == 16'd0) ? 16'd0 : remain_ff - 16'd1;

   // next state of the playback phase
   always_comb begin
      state_in    = state_ff;
      play_idx_in = play_idx_ff;
      sounding_in = sounding_ff;
      in_gap_in   = in_gap_ff;
      remain_in   = remain_ff;
      cur_hz_in   = cur_hz_ff;
      cur_gap_in  = cur_gap_ff;
      begin_req   = 1'b0;
      begin_idx   = play_idx_ff;
      clear_all   = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      dropped     = 1'b0;
      rsp_load    = 1'b0;

      if (state_ff == ST_LOAD) begin
         // note data is back from the store: start its tone or rest
         sounding_in = (rd_note.hz != 16'd0);
         in_gap_in   = (rd_note.hz == 16'd0);
         cur_hz_in   = rd_note.hz;
         remain_in   = rd_note.ms;
         cur_gap_in  = rd_note.gap;
         state_in    = ST_IDLE;
         rsp_load    = 1'b1;
      end else if (req_accept) begin
         unique case (req_word.command)
            CMD_TICK: begin
               if (note_count != '0) begin
                  remain_in = remain_dec;
                  if (remain_dec == 16'd0) begin
                     if (sounding_ff && !in_gap_ff) begin
                        sounding_in = 1'b0;
                        cur_hz_in   = 16'd0;
                        if (cur_gap_ff != 16'd0) begin
                           in_gap_in = 1'b1;
                           remain_in = cur_gap_ff;
                        end else begin
                           begin_req = 1'b1;
                           begin_idx = play_idx_ff + CNT_W'(1);
                        end
                     end else if (in_gap_ff) begin
                        in_gap_in = 1'b0;
                        begin_req = 1'b1;
                        begin_idx = play_idx_ff + CNT_W'(1);
                     end
                  end
               end
            end
            CMD_CLEAR: begin
               clear_all = 1'b1;
            end
            CMD_ENQUEUE: begin
               if (full) begin
                  dropped = 1'b1;
               end else begin
                  wr_en = 1'b1;
               end
            end
            CMD_START: begin
               begin_req = 1'b1;
               begin_idx = play_idx_ff;
            end
            default: begin
               clear_all = 1'b0;
            end
         endcase

         // begin a note: past the end the queue clears, else load it
         if (begin_req) begin
            if (begin_idx >= note_count) begin
               clear_all = 1'b1;
            end else begin
               rd_en       = 1'b1;
               play_idx_in = begin_idx;
               state_in    = ST_LOAD;
            end
         end

         if (clear_all) begin
            play_idx_in = '0;
            sounding_in = 1'b0;
            in_gap_in   = 1'b0;
            remain_in   = 16'd0;
            cur_hz_in   = 16'd0;
         end

         rsp_load = (state_in == ST_IDLE);
      end
   end

   // store control; entries being played never share an address with an append
   assign store_ctl.clear   = clear_all;
   assign store_ctl.wr_en   = wr_en;
   assign store_ctl.rd_en   = rd_en;
   assign store_ctl.rd_addr = begin_idx[ADDR_W-1:0];

   // fill count as it stands after this word
   always_comb begin
      cnt_next = note_count;
      if (clear_all) begin
         cnt_next = '0;
      end else if (wr_en) begin
         cnt_next = note_count + CNT_W'(1);
      end
   end

   // result word
   always_comb begin
      rsp_word_in.tone_on  = sounding_in;
      rsp_word_in.tone_hz  = sounding_in ? cur_hz_in : 16'd0;
      rsp_word_in.pwm_duty = sounding_in ? tone_duty : 8'd0;
      rsp_word_in.busy_res = (cnt_next != '0);
      rsp_word_in.dropped  = dropped;
      rsp_valid_in         = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         play_idx_ff  <= '0;
         sounding_ff  <= 1'b0;
         in_gap_ff    <= 1'b0;
         remain_ff    <= 16'd0;
         cur_hz_ff    <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         play_idx_ff  <= play_idx_in;
         sounding_ff  <= sounding_in;
         in_gap_ff    <= in_gap_in;
         remain_ff    <= remain_in;
         cur_hz_ff    <= cur_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_gap_ff <= cur_gap_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== design/bns_checker.sv =====
// ----------------------------------------------------------------------------
// bns_checker
// port-level checks on the result channel of the buzzer note sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "buzzer_note_sequencer_defines.svh"

module bns_checker
   import bns_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_word
);

   // a held result stays up and unchanged
   `BNS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "result word changed while stalled")

   // silence means no frequency and no duty
   `BNS_ASSERT_SAME(a_off_silent, rsp_valid && !rsp_word.tone_on, (rsp_word.tone_hz == 16'd0) && (rsp_word.pwm_duty == 8'd0), "silent word carries tone or duty")

   // a sounding tone has a nonzero frequency and comes from a stored note
   `BNS_ASSERT_SAME(a_on_note, rsp_valid && rsp_word.tone_on, (rsp_word.tone_hz != 16'd0) && rsp_word.busy_res, "tone sounds without a stored note")

   // a refused note means the store is holding notes
   `BNS_ASSERT_SAME(a_drop_busy, rsp_valid && rsp_word.dropped, rsp_word.busy_res, "note dropped while store is empty")

endmodule

bind buzzer_note_sequencer bns_checker u_bns_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire
